>>> hw/rtl/jsu_pkg.sv
// Shared types, constants and character helpers of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

	// Largest output buffer, terminator included.
	localparam int MAX_OUTPUT = 4096;

	localparam int CHAR_W    = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_RESET = 256;
	localparam int EMIT_W    = $clog2(MAX_OUTPUT);
	localparam int LIM_W     = (CFG_W > EMIT_W + 1) ? CFG_W : EMIT_W + 1;

	// Hex digits held while a \u escape is collected (the fourth completes it).
	localparam int HELD_DEPTH = 3;
	localparam int HELD_IDX_W = $clog2(HELD_DEPTH + 1);

	// A command carries at most 'u', three held digits and one more character.
	localparam int CMD_CHARS = HELD_DEPTH + 2;
	localparam int CNT_W     = $clog2(CMD_CHARS + 1);

	// Command queue between decoder and emitter.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_U      = 8'h75;
	localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
	localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
	localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
	localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
	localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              out_end;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESCAPE,
		MODE_HEX
	} mode_t;

	// One decoded request for the emitter: a run of characters and a terminator flag.
	typedef struct packed {
		logic [CMD_CHARS-1:0][CHAR_W-1:0] chars;
		logic [CNT_W-1:0]                 cnt;
		logic                             term;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] nib;
	} hex_t;

	// Value of a hex digit in either case.
	function automatic hex_t hex_nibble(input logic [CHAR_W-1:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.nib   = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nib = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nib = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nib = 4'(c - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

	// Character produced by a backslash escape other than \u.
	function automatic logic [CHAR_W-1:0] escape_map(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] m;
		case (c)
			CH_B: begin
				m = CH_BS;
			end
			CH_F: begin
				m = CH_FF;
			end
			CH_N: begin
				m = CH_LF;
			end
			CH_R: begin
				m = CH_CR;
			end
			CH_T: begin
				m = CH_TAB;
			end
			default: begin
				m = c;
			end
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jsu_front.sv
// Front end: accepts escaped bytes, tracks escape state and issues emit requests.
`default_nettype none

module jsu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire jsu_pkg::in_item_t in_item,
	output logic                  cmd_push,
	output jsu_pkg::cmd_t         cmd,
	input  wire logic             cmd_full
);

	jsu_pkg::mode_t                   mode_q, mode_d;
	logic [jsu_pkg::HELD_IDX_W-1:0]   held_cnt_q, held_cnt_d;
	logic [jsu_pkg::CHAR_W-1:0]       held_q [jsu_pkg::HELD_DEPTH];

	logic                             accept;
	logic [jsu_pkg::CHAR_W-1:0]       c;
	logic                             last;
	jsu_pkg::hex_t                    hx;
	jsu_pkg::hex_t                    h0, h1, h2;
	logic                             is_bslash;
	logic                             held_full;
	logic [jsu_pkg::CHAR_W-1:0]       code_char;
	logic                             flush;
	logic                             tail_v;
	logic [jsu_pkg::CHAR_W-1:0]       tail;
	logic                             wr_held;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign c      = in_item.in_char;
	assign last   = in_item.in_last;
	assign hx     = jsu_pkg::hex_nibble(c);
	assign h0     = jsu_pkg::hex_nibble(held_q[0]);
	assign h1     = jsu_pkg::hex_nibble(held_q[1]);
	assign h2     = jsu_pkg::hex_nibble(held_q[2]);
	assign is_bslash = (c == jsu_pkg::CH_BSLASH);
	assign held_full = (held_cnt_q == jsu_pkg::HELD_IDX_W'(jsu_pkg::HELD_DEPTH));

	// A completed \u code fits in seven bits only when its top nine bits are zero.
	assign code_char = (h0.nib == 4'h0 && h1.nib == 4'h0 && !h2.nib[3]) ?
		{h2.nib, hx.nib} : jsu_pkg::CH_QMARK;

	// Next decode mode.
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			jsu_pkg::MODE_ESCAPE: begin
				if (c == jsu_pkg::CH_U && !last) begin
					mode_d = jsu_pkg::MODE_HEX;
				end else begin
					mode_d = jsu_pkg::MODE_NORMAL;
				end
			end
			jsu_pkg::MODE_HEX: begin
				if (hx.valid) begin
					if (held_full || last) begin
						mode_d = jsu_pkg::MODE_NORMAL;
					end
				end else if (is_bslash && !last) begin
					mode_d = jsu_pkg::MODE_ESCAPE;
				end else begin
					mode_d = jsu_pkg::MODE_NORMAL;
				end
			end
			default: begin
				if (is_bslash && !last) begin
					mode_d = jsu_pkg::MODE_ESCAPE;
				end else begin
					mode_d = jsu_pkg::MODE_NORMAL;
				end
			end
		endcase
		if (last) begin
			mode_d = jsu_pkg::MODE_NORMAL;
		end
	end

	// Classification of the byte: what to emit and how the held digits change.
	always_comb begin
		flush      = 1'b0;
		tail_v     = 1'b0;
		tail       = c;
		wr_held    = 1'b0;
		held_cnt_d = held_cnt_q;
		case (mode_q)
			jsu_pkg::MODE_ESCAPE: begin
				held_cnt_d = '0;
				if (c == jsu_pkg::CH_U) begin
					tail_v = last;
				end else begin
					tail_v = 1'b1;
					tail   = jsu_pkg::escape_map(c);
				end
			end
			jsu_pkg::MODE_HEX: begin
				if (hx.valid) begin
					if (held_full) begin
						tail_v     = 1'b1;
						tail       = code_char;
						held_cnt_d = '0;
					end else begin
						wr_held    = 1'b1;
						held_cnt_d = held_cnt_q + jsu_pkg::HELD_IDX_W'(1);
						flush      = last;
						tail_v     = last;
					end
				end else begin
					flush      = 1'b1;
					held_cnt_d = '0;
					tail_v     = !(is_bslash && !last);
				end
			end
			default: begin
				tail_v = !(is_bslash && !last);
			end
		endcase
		if (last) begin
			held_cnt_d = '0;
		end
	end

	// Request assembly: an optional 'u' with the held digits, then the tail character.
	always_comb begin
		cmd.chars = '0;
		cmd.term  = last;
		if (flush) begin
			cmd.chars[0] = jsu_pkg::CH_U;
			for (int k = 0; k < jsu_pkg::HELD_DEPTH; k++) begin
				cmd.chars[k + 1] = held_q[k];
			end
			cmd.chars[jsu_pkg::CNT_W'(held_cnt_q) + jsu_pkg::CNT_W'(1)] = tail;
			cmd.cnt = jsu_pkg::CNT_W'(held_cnt_q) + jsu_pkg::CNT_W'(1)
				+ jsu_pkg::CNT_W'(tail_v);
		end else begin
			cmd.chars[0] = tail;
			cmd.cnt      = jsu_pkg::CNT_W'(tail_v);
		end
	end

	// Only requests that produce something go into the queue.
	assign cmd_push = accept && ((cmd.cnt != '0) || last);

	// Decode state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= jsu_pkg::MODE_NORMAL;
			held_cnt_q <= '0;
		end else if (accept) begin
			mode_q     <= mode_d;
			held_cnt_q <= held_cnt_d;
		end
	end

	// Held hex digits.
	always_ff @(posedge clk) begin
		if (accept && wr_held) begin
			held_q[held_cnt_q] <= c;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/jsu_cmd_fifo.sv
// Short request queue between the decoder front end and the emitter back end.
`default_nettype none

module jsu_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire jsu_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output jsu_pkg::cmd_t      rd_data,
	output logic               empty
);

	jsu_pkg::cmd_t               mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [jsu_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [jsu_pkg::QCNT_W-1:0]  count_q;

	assign full    = (count_q == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Pointer advance with wrap at the queue depth.
	function automatic logic [jsu_pkg::QPTR_W-1:0] ptr_next(
		input logic [jsu_pkg::QPTR_W-1:0] p
	);
		logic [jsu_pkg::QPTR_W-1:0] n;
		if (p == jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + jsu_pkg::QPTR_W'(1);
		end
		return n;
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + jsu_pkg::QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - jsu_pkg::QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("request written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("request read from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH))
		else $error("queue fill count beyond its depth");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/jsu_back.sv
// Back end: walks each request one character per cycle unless stalled; caps output.
`default_nettype none

module jsu_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [jsu_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      cmd_empty,
	input  wire jsu_pkg::cmd_t             cmd,
	output logic                           cmd_pop,
	output logic                           empty,
	input  wire logic                      pop,
	output jsu_pkg::out_item_t             out_item
);

	logic [jsu_pkg::CFG_W-1:0]  cap_q;
	logic [jsu_pkg::EMIT_W-1:0] emit_cnt_q;
	logic [jsu_pkg::CNT_W-1:0]  idx_q, idx_d;
	logic                       out_valid_q;
	jsu_pkg::out_item_t         out_q;

	logic [jsu_pkg::LIM_W-1:0]  cap_ext;
	logic [jsu_pkg::LIM_W-1:0]  cap_eff;
	logic                       room;
	logic                       step;
	logic                       in_chars;
	logic                       load;
	jsu_pkg::out_item_t         load_item;
	logic                       emit_inc;
	logic                       emit_clr;

	assign cfg_ready = 1'b1;
	assign empty     = !out_valid_q;
	assign out_item  = out_q;

	// Effective capacity: zero acts as one, anything above the maximum is clamped.
	assign cap_ext = jsu_pkg::LIM_W'(cap_q);
	always_comb begin
		cap_eff = cap_ext;
		if (cap_q == '0) begin
			cap_eff = jsu_pkg::LIM_W'(1);
		end else if (cap_ext > jsu_pkg::LIM_W'(jsu_pkg::MAX_OUTPUT)) begin
			cap_eff = jsu_pkg::LIM_W'(jsu_pkg::MAX_OUTPUT);
		end
	end

	assign room     = (jsu_pkg::LIM_W'(emit_cnt_q) + jsu_pkg::LIM_W'(1)) < cap_eff;
	assign step     = !cmd_empty && (!out_valid_q || pop);
	assign in_chars = idx_q < cmd.cnt;

	// One step through the head request: a character, or the terminator.
	always_comb begin
		load      = 1'b0;
		load_item = '{out_char: cmd.chars[idx_q], out_end: 1'b0};
		emit_inc  = 1'b0;
		emit_clr  = 1'b0;
		cmd_pop   = 1'b0;
		idx_d     = idx_q;
		if (step) begin
			if (in_chars) begin
				if (room) begin
					load     = 1'b1;
					emit_inc = 1'b1;
				end
				if ((idx_q + jsu_pkg::CNT_W'(1) == cmd.cnt) && !cmd.term) begin
					cmd_pop = 1'b1;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + jsu_pkg::CNT_W'(1);
				end
			end else begin
				if (cmd.term) begin
					load      = 1'b1;
					load_item = '{out_char: jsu_pkg::CH_NUL, out_end: 1'b1};
					emit_clr  = 1'b1;
				end
				cmd_pop = 1'b1;
				idx_d   = '0;
			end
		end
	end

	// Control state: capacity register, emitted count, position, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= jsu_pkg::CFG_W'(jsu_pkg::CFG_RESET);
			emit_cnt_q  <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (emit_clr) begin
				emit_cnt_q <= '0;
			end else if (emit_inc) begin
				emit_cnt_q <= emit_cnt_q + jsu_pkg::EMIT_W'(1);
			end
			idx_q <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_item;
		end
	end

`ifndef SYNTHESIS
	a_term_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_item.out_end) |=> (emit_cnt_q == '0))
		else $error("emitted count not cleared after a terminator");

	a_mid_request_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> !cmd_empty)
		else $error("request position set with no request at the head");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_empty |-> (idx_q <= cmd.cnt))
		else $error("request position beyond the request length");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/json_string_unescaper_unit.sv
// Top level of the JSON string unescaper: decoder, request queue and emitter.
`default_nettype none

// Streaming JSON string-body unescaper. Escaped bytes enter through push/full,
// one byte per cycle while full is low; the decoder front end turns each byte
// into a request of zero to five characters plus an optional terminator and
// queues each non-empty request in a two-entry queue. The emitter back end
// produces one result per cycle from the queue head into an output register
// read through empty/pop, while that register is empty or popped, so a byte
// that yields one character sustains one item per cycle; a terminator, up to
// six results of a replayed broken \u escape and any character dropped at the
// capacity each take an emitter step. The user must write the out_capacity
// register through cfg_valid/cfg_ready only while the block is idle; the block
// does not enforce this. A string holds under max(out_capacity, 1) characters.
module json_string_unescaper_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire jsu_pkg::in_item_t         in_item,
	output logic                           empty,
	input  wire logic                      pop,
	output jsu_pkg::out_item_t             out_item,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [jsu_pkg::CFG_W-1:0] cfg_data
);

	logic          wr_en;
	jsu_pkg::cmd_t wr_data;
	logic          q_full;
	logic          rd_en;
	jsu_pkg::cmd_t rd_data;
	logic          q_empty;

	// Decoder front end.
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.cmd_push (wr_en),
		.cmd      (wr_data),
		.cmd_full (q_full)
	);

	// Request queue.
	jsu_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (q_full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.empty   (q_empty)
	);

	// Emitter back end.
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_empty (q_empty),
		.cmd       (rd_data),
		.cmd_pop   (rd_en),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
